// ===== hdl/k_core_peeling_engine_top_assert.svh =====
// Assertion macros used by the k-core peeling engine sequencer (kcp_ctrl).
`ifndef K_CORE_PEELING_ENGINE_TOP_ASSERT_SVH
`define K_CORE_PEELING_ENGINE_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KCP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("kcp assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define KCP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("kcp assertion failed");

`endif

// ===== hdl/kcp_pkg.sv =====
// Types and constants of the k-core peeling engine.
`default_nettype none
package kcp_pkg;

  localparam int unsigned VERTICES   = 1024;
  localparam int unsigned VTX_W      = $clog2(VERTICES);
  localparam int unsigned EDGE_SLOTS = 8192;
  localparam int unsigned EDGE_AW    = $clog2(EDGE_SLOTS);
  localparam int unsigned ETOT_W     = EDGE_AW + 1;
  localparam int unsigned FIELD_W    = 10;
  localparam int unsigned ACT_W      = 3;
  localparam int unsigned STAT_W     = 2;
  localparam logic [FIELD_W-1:0] DEG_MAX = {FIELD_W{1'b1}};
  localparam logic [FIELD_W-1:0] K_MAX   = {FIELD_W{1'b1}};
  localparam logic [VTX_W-1:0]   LAST_V  = VTX_W'(VERTICES - 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR = 3'd0,
    ACT_ADDV  = 3'd1,
    ACT_ADDE  = 3'd2,
    ACT_RUN   = 3'd3,
    ACT_QUERY = 3'd4
  } action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_UNDECL  = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef struct packed {
    logic               present;
    logic [FIELD_W-1:0] deg;
    logic [FIELD_W-1:0] rem;
    logic               alive;
    logic               known;
    logic [FIELD_W-1:0] core;
  } vtx_t;

  typedef struct packed {
    logic [VTX_W-1:0] va;
    logic [VTX_W-1:0] vb;
  } edge_t;

  typedef struct packed {
    logic             rd_en;
    logic [VTX_W-1:0] rd_addr;
    logic             wr_en;
    logic [VTX_W-1:0] wr_addr;
    vtx_t             wr_data;
  } vram_req_t;

  typedef struct packed {
    logic               rd_en;
    logic [EDGE_AW-1:0] rd_addr;
    logic               wr_en;
    logic [EDGE_AW-1:0] wr_addr;
    edge_t              wr_data;
  } eram_req_t;

endpackage
`default_nettype wire

// ===== hdl/kcp_if.sv =====
// Valid/ready channel interfaces for command and result beats.
`default_nettype none
interface kcp_in_if;
  logic                        valid;
  logic                        ready;
  logic [kcp_pkg::ACT_W-1:0]   action;
  logic [kcp_pkg::FIELD_W-1:0] vertex_a;
  logic [kcp_pkg::FIELD_W-1:0] vertex_b;
  modport source (output valid, action, vertex_a, vertex_b, input ready);
  modport sink (input valid, action, vertex_a, vertex_b, output ready);
endinterface

interface kcp_out_if;
  logic                        valid;
  logic                        ready;
  logic [kcp_pkg::STAT_W-1:0]  status;
  logic [kcp_pkg::FIELD_W-1:0] core_number;
  logic [kcp_pkg::FIELD_W-1:0] highest_core;
  modport source (output valid, status, core_number, highest_core, input ready);
  modport sink (input valid, status, core_number, highest_core, output ready);
endinterface
`default_nettype wire

// ===== hdl/kcp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module kcp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             rd_en_i,
  input  wire logic [AW-1:0]    rd_addr_i,
  input  wire logic             wr_en_i,
  input  wire logic [AW-1:0]    wr_addr_i,
  input  wire logic [WIDTH-1:0] wr_data_i,
  output logic      [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/kcp_ctrl.sv =====
// Command sequencer: loads, queries, clears and peels through the two RAMs.
`default_nettype none
module kcp_ctrl (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  kcp_in_if.sink                           in_i,
  kcp_out_if.source                        out_o,
  output kcp_pkg::vram_req_t               vreq_o,
  input  wire logic [$bits(kcp_pkg::vtx_t)-1:0]  vrdata_i,
  output kcp_pkg::eram_req_t               ereq_o,
  input  wire logic [$bits(kcp_pkg::edge_t)-1:0] erdata_i
);

  typedef enum logic [14:0] {
    S_CLR     = 15'b000000000000001,
    S_IDLE    = 15'b000000000000010,
    S_A       = 15'b000000000000100,
    S_B       = 15'b000000000001000,
    S_EB      = 15'b000000000010000,
    S_RESP    = 15'b000000000100000,
    S_INIT_RD = 15'b000000001000000,
    S_INIT_WR = 15'b000000010000000,
    S_LVL     = 15'b000000100000000,
    S_SRD     = 15'b000001000000000,
    S_SEV     = 15'b000010000000000,
    S_NXT     = 15'b000100000000000,
    S_EEV     = 15'b001000000000000,
    S_OWB     = 15'b010000000000000,
    S_ENX     = 15'b100000000000000
  } state_e;

  state_e state_q, state_d;
  logic [kcp_pkg::ACT_W-1:0]   act_q, act_d;
  logic [kcp_pkg::VTX_W-1:0]   a_q, a_d, b_q, b_d, o_q, o_d, cnt_q, cnt_d;
  kcp_pkg::vtx_t               wa_q, wa_d, wb_q, wb_d;
  logic [kcp_pkg::ETOT_W-1:0]  e_q, e_d, etot_q, etot_d;
  logic [kcp_pkg::FIELD_W-1:0] peak_q, peak_d, k_q, k_d;
  logic [kcp_pkg::VTX_W:0]     alive_q, alive_d;
  logic                        removed_q, removed_d, clr_rsp_q, clr_rsp_d;
  logic [kcp_pkg::STAT_W-1:0]  rst_q, rst_d;
  logic [kcp_pkg::FIELD_W-1:0] rcore_q, rcore_d;
  logic                        out_vld_q, out_vld_d;
  logic [kcp_pkg::STAT_W-1:0]  out_st_q, out_st_d;
  logic [kcp_pkg::FIELD_W-1:0] out_core_q, out_core_d, out_high_q, out_high_d;

  kcp_pkg::vtx_t               vq, vw;
  kcp_pkg::edge_t              eq;
  logic [kcp_pkg::ETOT_W-1:0]  e_inc;
  logic                        accept, out_load, remove, match_a, match_b;

  assign vq       = kcp_pkg::vtx_t'(vrdata_i);
  assign eq       = kcp_pkg::edge_t'(erdata_i);
  assign e_inc    = e_q + 1'b1;
  assign accept   = in_i.valid && in_i.ready;
  assign out_load = (state_q == S_RESP) && (!out_vld_q || out_o.ready);
  assign remove   = (state_q == S_SEV) && vq.alive && (vq.rem <= k_q);
  assign match_a  = (eq.va == cnt_q);
  assign match_b  = (eq.vb == cnt_q);

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_vld_q;
  assign out_o.status       = out_st_q;
  assign out_o.core_number  = out_core_q;
  assign out_o.highest_core = out_high_q;

  always_comb begin
    state_d   = state_q;
    act_d     = act_q;
    a_d       = a_q;
    b_d       = b_q;
    o_d       = o_q;
    cnt_d     = cnt_q;
    wa_d      = wa_q;
    wb_d      = wb_q;
    e_d       = e_q;
    etot_d    = etot_q;
    peak_d    = peak_q;
    k_d       = k_q;
    alive_d   = alive_q;
    removed_d = removed_q;
    clr_rsp_d = clr_rsp_q;
    rst_d     = rst_q;
    rcore_d   = rcore_q;
    vw        = vq;
    vreq_o    = '0;
    ereq_o    = '0;

    case (state_q)
      S_CLR: begin
        vreq_o.wr_en   = 1'b1;
        vreq_o.wr_addr = cnt_q;
        vreq_o.wr_data = '0;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == kcp_pkg::LAST_V) begin
          etot_d  = '0;
          peak_d  = '0;
          state_d = clr_rsp_q ? S_RESP : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          act_d   = in_i.action;
          a_d     = in_i.vertex_a;
          b_d     = in_i.vertex_b;
          rst_d   = kcp_pkg::ST_OK;
          rcore_d = '0;
          case (in_i.action)
            kcp_pkg::ACT_CLEAR: begin
              cnt_d     = '0;
              clr_rsp_d = 1'b1;
              state_d   = S_CLR;
            end
            kcp_pkg::ACT_ADDV, kcp_pkg::ACT_ADDE, kcp_pkg::ACT_QUERY: begin
              vreq_o.rd_en   = 1'b1;
              vreq_o.rd_addr = in_i.vertex_a;
              state_d        = S_A;
            end
            kcp_pkg::ACT_RUN: begin
              cnt_d   = '0;
              alive_d = '0;
              state_d = S_INIT_RD;
            end
            default: state_d = S_RESP;
          endcase
        end
      end
      S_A: begin
        case (act_q)
          kcp_pkg::ACT_ADDV: begin
            vw.present     = 1'b1;
            vreq_o.wr_en   = 1'b1;
            vreq_o.wr_addr = a_q;
            vreq_o.wr_data = vw;
            state_d        = S_RESP;
          end
          kcp_pkg::ACT_QUERY: begin
            if (vq.present && vq.known) begin
              rcore_d = vq.core;
            end else begin
              rst_d = kcp_pkg::ST_UNKNOWN;
            end
            state_d = S_RESP;
          end
          default: begin
            wa_d           = vq;
            vreq_o.rd_en   = 1'b1;
            vreq_o.rd_addr = b_q;
            state_d        = S_B;
          end
        endcase
      end
      S_B: begin
        wb_d    = vq;
        state_d = S_RESP;
        if (!wa_q.present || !vq.present) begin
          rst_d = kcp_pkg::ST_UNDECL;
        end else if (a_q == b_q) begin
          rst_d = kcp_pkg::ST_OK;
        end else if (etot_q == kcp_pkg::ETOT_W'(kcp_pkg::EDGE_SLOTS) ||
                     wa_q.deg == kcp_pkg::DEG_MAX || vq.deg == kcp_pkg::DEG_MAX) begin
          rst_d = kcp_pkg::ST_FULL;
        end else begin
          vw             = wa_q;
          vw.deg         = wa_q.deg + 1'b1;
          vreq_o.wr_en   = 1'b1;
          vreq_o.wr_addr = a_q;
          vreq_o.wr_data = vw;
          ereq_o.wr_en   = 1'b1;
          ereq_o.wr_addr = etot_q[kcp_pkg::EDGE_AW-1:0];
          ereq_o.wr_data = '{va: a_q, vb: b_q};
          etot_d         = etot_q + 1'b1;
          state_d        = S_EB;
        end
      end
      S_EB: begin
        vw             = wb_q;
        vw.deg         = wb_q.deg + 1'b1;
        vreq_o.wr_en   = 1'b1;
        vreq_o.wr_addr = b_q;
        vreq_o.wr_data = vw;
        state_d        = S_RESP;
      end
      S_RESP: begin
        if (out_load) begin
          clr_rsp_d = 1'b0;
          state_d   = S_IDLE;
        end
      end
      S_INIT_RD: begin
        vreq_o.rd_en   = 1'b1;
        vreq_o.rd_addr = cnt_q;
        state_d        = S_INIT_WR;
      end
      S_INIT_WR: begin
        vw.rem         = vq.deg;
        vw.alive       = vq.present;
        vw.known       = 1'b0;
        vreq_o.wr_en   = 1'b1;
        vreq_o.wr_addr = cnt_q;
        vreq_o.wr_data = vw;
        alive_d        = alive_q + {{kcp_pkg::VTX_W{1'b0}}, vq.present};
        cnt_d          = cnt_q + 1'b1;
        state_d        = S_INIT_RD;
        if (cnt_q == kcp_pkg::LAST_V) begin
          k_d     = kcp_pkg::FIELD_W'(1);
          peak_d  = kcp_pkg::FIELD_W'(1);
          state_d = (alive_d == '0) ? S_RESP : S_LVL;
        end
      end
      S_LVL: begin
        peak_d    = k_q;
        cnt_d     = '0;
        removed_d = 1'b0;
        state_d   = S_SRD;
      end
      S_SRD: begin
        vreq_o.rd_en   = 1'b1;
        vreq_o.rd_addr = cnt_q;
        state_d        = S_SEV;
      end
      S_SEV: begin
        state_d = S_NXT;
        if (remove) begin
          vw.alive       = 1'b0;
          vw.known       = 1'b1;
          vw.core        = k_q;
          vreq_o.wr_en   = 1'b1;
          vreq_o.wr_addr = cnt_q;
          vreq_o.wr_data = vw;
          alive_d        = alive_q - 1'b1;
          removed_d      = 1'b1;
          e_d            = '0;
          if (etot_q != '0) begin
            ereq_o.rd_en   = 1'b1;
            ereq_o.rd_addr = '0;
            state_d        = S_EEV;
          end
        end
      end
      S_NXT: begin
        if (cnt_q == kcp_pkg::LAST_V) begin
          cnt_d = '0;
          if (removed_q) begin
            removed_d = 1'b0;
            state_d   = S_SRD;
          end else if (alive_q == '0 || k_q == kcp_pkg::K_MAX) begin
            state_d = S_RESP;
          end else begin
            k_d     = k_q + 1'b1;
            state_d = S_LVL;
          end
        end else begin
          cnt_d   = cnt_q + 1'b1;
          state_d = S_SRD;
        end
      end
      S_EEV: begin
        state_d = S_ENX;
        if (match_a || match_b) begin
          o_d            = match_a ? eq.vb : eq.va;
          vreq_o.rd_en   = 1'b1;
          vreq_o.rd_addr = match_a ? eq.vb : eq.va;
          state_d        = S_OWB;
        end
      end
      S_OWB: begin
        if (vq.alive) begin
          vw.rem         = (vq.rem != '0) ? vq.rem - 1'b1 : vq.rem;
          vreq_o.wr_en   = 1'b1;
          vreq_o.wr_addr = o_q;
          vreq_o.wr_data = vw;
        end
        state_d = S_ENX;
      end
      S_ENX: begin
        if (e_inc == etot_q) begin
          state_d = S_NXT;
        end else begin
          e_d            = e_inc;
          ereq_o.rd_en   = 1'b1;
          ereq_o.rd_addr = e_inc[kcp_pkg::EDGE_AW-1:0];
          state_d        = S_EEV;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_vld_d  = out_vld_q && !out_o.ready;
    out_st_d   = out_st_q;
    out_core_d = out_core_q;
    out_high_d = out_high_q;
    if (out_load) begin
      out_vld_d  = 1'b1;
      out_st_d   = rst_q;
      out_core_d = rcore_q;
      out_high_d = peak_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLR;
      cnt_q     <= '0;
      etot_q    <= '0;
      peak_q    <= '0;
      clr_rsp_q <= 1'b0;
      out_vld_q <= 1'b0;
      alive_q   <= '0;
      removed_q <= 1'b0;
      k_q       <= '0;
      e_q       <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      etot_q    <= etot_d;
      peak_q    <= peak_d;
      clr_rsp_q <= clr_rsp_d;
      out_vld_q <= out_vld_d;
      alive_q   <= alive_d;
      removed_q <= removed_d;
      k_q       <= k_d;
      e_q       <= e_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q      <= act_d;
    a_q        <= a_d;
    b_q        <= b_d;
    o_q        <= o_d;
    wa_q       <= wa_d;
    wb_q       <= wb_d;
    rst_q      <= rst_d;
    rcore_q    <= rcore_d;
    out_st_q   <= out_st_d;
    out_core_q <= out_core_d;
    out_high_q <= out_high_d;
  end

`include "k_core_peeling_engine_top_assert.svh"

  `KCP_ASSERT_IMP(a_dual_write, vreq_o.wr_en && ereq_o.wr_en, state_q == S_B)
  `KCP_ASSERT_NXT(a_accept_busy, accept, state_q != S_IDLE)
  `KCP_ASSERT_IMP(a_etot_bound, 1'b1, etot_q <= kcp_pkg::ETOT_W'(kcp_pkg::EDGE_SLOTS))
  `KCP_ASSERT_NXT(a_alive_dec, remove, alive_q == $past(alive_q) - 1'b1)

endmodule
`default_nettype wire

// ===== hdl/k_core_peeling_engine_top.sv =====
// Top level of the k-core peeling engine: sequencer plus vertex and edge RAMs.
//
//  channel  | dir | payload
//  in_i     | in  | action, vertex_a, vertex_b
//  out_o    | out | status, core_number, highest_core
//
// Add vertex and query read one vertex entry; add edge reads and writes its two vertices
// in turn, as the vertex RAM has one read port and one write port.
// Clear graph writes one vertex RAM entry per cycle. Run first rewrites every vertex entry,
// then scans all vertices in each pass and walks all stored edges for every removed vertex.
// After reset a clearing pass over all vertex entries runs before the first beat is taken.
// A finished result waits in an output register; the next beat is taken meanwhile.
`default_nettype none
module k_core_peeling_engine_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  kcp_in_if.sink    in_i,
  kcp_out_if.source out_o
);

  kcp_pkg::vram_req_t                        vreq;
  kcp_pkg::eram_req_t                        ereq;
  logic [$bits(kcp_pkg::vtx_t)-1:0]          vrdata;
  logic [$bits(kcp_pkg::edge_t)-1:0]         erdata;

  kcp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_i     (in_i),
    .out_o    (out_o),
    .vreq_o   (vreq),
    .vrdata_i (vrdata),
    .ereq_o   (ereq),
    .erdata_i (erdata)
  );

  kcp_ram #(
    .WIDTH ($bits(kcp_pkg::vtx_t)),
    .DEPTH (kcp_pkg::VERTICES)
  ) u_vtx_ram (
    .clk_i     (clk_i),
    .rd_en_i   (vreq.rd_en),
    .rd_addr_i (vreq.rd_addr),
    .wr_en_i   (vreq.wr_en),
    .wr_addr_i (vreq.wr_addr),
    .wr_data_i (vreq.wr_data),
    .rd_data_o (vrdata)
  );

  kcp_ram #(
    .WIDTH ($bits(kcp_pkg::edge_t)),
    .DEPTH (kcp_pkg::EDGE_SLOTS)
  ) u_edge_ram (
    .clk_i     (clk_i),
    .rd_en_i   (ereq.rd_en),
    .rd_addr_i (ereq.rd_addr),
    .wr_en_i   (ereq.wr_en),
    .wr_addr_i (ereq.wr_addr),
    .wr_data_i (ereq.wr_data),
    .rd_data_o (erdata)
  );

endmodule
`default_nettype wire
